// ===== rtl/core/hierarchical_timing_wheel_top_defines.svh =====
// assertion helpers used by the checker file htw_checker.sv
`ifndef HIERARCHICAL_TIMING_WHEEL_TOP_DEFINES_SVH
`define HIERARCHICAL_TIMING_WHEEL_TOP_DEFINES_SVH

// same-cycle implication
`define HTW_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTW_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/htw_pkg.sv =====
package htw_pkg;

  localparam int SLOT_BITS   = 6;
  localparam int LEVEL_COUNT = 4;
  localparam int TIMER_COUNT = 64;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;
  localparam logic [1:0] CMD_GET  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  timer_id;
    logic [63:0] time_value;
  } request_t;

  typedef struct packed {
    logic        expired_valid;
    logic [5:0]  expired_timer;
    logic        any_pending;
    logic [63:0] next_timeout;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_DET_RD, ST_DET_WR, ST_FIL_RD, ST_FIL_WR, ST_FIL_LINK,
    ST_GET_RD, ST_GET_WR, ST_STP_INIT, ST_STP_SHF, ST_STP_DUE, ST_STP_SCAN,
    ST_STP_SPL, ST_STP_NEXT, ST_STP_CUR, ST_REF_RD, ST_REF_WR, ST_NW_INIT,
    ST_NW_ROT, ST_NW_CTZ, ST_NW_CMP, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DET_RD, OP_DET_WR, OP_FIL_RD, OP_FIL_WR, OP_FIL_LINK,
    OP_GET_RD, OP_GET_WR, OP_STP_INIT, OP_STP_SHF, OP_STP_DUE, OP_STP_SCAN,
    OP_STP_SPL, OP_STP_NEXT, OP_STP_CUR, OP_REF_RD, OP_REF_WR, OP_NW_INIT,
    OP_NW_ROT, OP_NW_CTZ, OP_NW_CMP, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       id_ok;
    logic       queued;
    logic       exp_empty;
    logic       h_nil;
    logic       hit_any;
    logic       due0;
    logic       lvl_last;
    logic       todo_empty;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/htw_ctrl.sv =====
module htw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  output htw_pkg::ctrl_cmd_t ctl,
  input  htw_pkg::dp_stat_t stat
);

  htw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // file path returns to refile loop during step
  htw_pkg::state_t after_file;
  assign after_file = (stat.cmd == htw_pkg::CMD_STEP) ? htw_pkg::ST_REF_RD : htw_pkg::ST_NW_INIT;

  always_comb begin
    state_next = state;
    unique case (state)
      htw_pkg::ST_IDLE:     if (request_valid) state_next = htw_pkg::ST_DISP;
      htw_pkg::ST_DISP: begin
        unique case (stat.cmd)
          htw_pkg::CMD_ADD:  state_next = !stat.id_ok ? htw_pkg::ST_NW_INIT :
                                         stat.queued ? htw_pkg::ST_DET_RD : htw_pkg::ST_FIL_RD;
          htw_pkg::CMD_DEL:  state_next = (stat.id_ok && stat.queued) ? htw_pkg::ST_DET_RD :
                                                                        htw_pkg::ST_NW_INIT;
          htw_pkg::CMD_STEP: state_next = htw_pkg::ST_STP_INIT;
          default:           state_next = stat.exp_empty ? htw_pkg::ST_NW_INIT :
                                                           htw_pkg::ST_GET_RD;
        endcase
      end
      htw_pkg::ST_DET_RD:   state_next = htw_pkg::ST_DET_WR;
      htw_pkg::ST_DET_WR:   state_next = (stat.cmd == htw_pkg::CMD_ADD) ? htw_pkg::ST_FIL_RD :
                                                                        htw_pkg::ST_NW_INIT;
      htw_pkg::ST_FIL_RD:   state_next = htw_pkg::ST_FIL_WR;
      htw_pkg::ST_FIL_WR:   state_next = stat.h_nil ? after_file : htw_pkg::ST_FIL_LINK;
      htw_pkg::ST_FIL_LINK: state_next = after_file;
      htw_pkg::ST_GET_RD:   state_next = htw_pkg::ST_GET_WR;
      htw_pkg::ST_GET_WR:   state_next = htw_pkg::ST_NW_INIT;
      htw_pkg::ST_STP_INIT: state_next = htw_pkg::ST_STP_SHF;
      htw_pkg::ST_STP_SHF:  state_next = htw_pkg::ST_STP_DUE;
      htw_pkg::ST_STP_DUE:  state_next = htw_pkg::ST_STP_SCAN;
      htw_pkg::ST_STP_SCAN: begin
        if (stat.hit_any)                    state_next = htw_pkg::ST_STP_SPL;
        else if (!stat.due0 || stat.lvl_last) state_next = htw_pkg::ST_STP_CUR;
        else                                 state_next = htw_pkg::ST_STP_NEXT;
      end
      htw_pkg::ST_STP_SPL:  state_next = htw_pkg::ST_STP_SCAN;
      htw_pkg::ST_STP_NEXT: state_next = htw_pkg::ST_STP_SHF;
      htw_pkg::ST_STP_CUR:  state_next = htw_pkg::ST_REF_RD;
      htw_pkg::ST_REF_RD:   state_next = stat.todo_empty ? htw_pkg::ST_NW_INIT :
                                                           htw_pkg::ST_REF_WR;
      htw_pkg::ST_REF_WR:   state_next = htw_pkg::ST_FIL_RD;
      htw_pkg::ST_NW_INIT:  state_next = stat.exp_empty ? htw_pkg::ST_NW_ROT : htw_pkg::ST_DONE;
      htw_pkg::ST_NW_ROT:   state_next = htw_pkg::ST_NW_CTZ;
      htw_pkg::ST_NW_CTZ:   state_next = htw_pkg::ST_NW_CMP;
      htw_pkg::ST_NW_CMP:   state_next = stat.lvl_last ? htw_pkg::ST_DONE : htw_pkg::ST_NW_ROT;
      htw_pkg::ST_DONE:     if (stat.out_free) state_next = htw_pkg::ST_IDLE;
      default:              state_next = htw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    request_stall = (state != htw_pkg::ST_IDLE);
    ctl.op = htw_pkg::OP_NONE;
    unique case (state)
      htw_pkg::ST_IDLE:     ctl.op = request_valid ? htw_pkg::OP_LOAD : htw_pkg::OP_NONE;
      htw_pkg::ST_DISP:     ctl.op = htw_pkg::OP_NONE;
      htw_pkg::ST_DET_RD:   ctl.op = htw_pkg::OP_DET_RD;
      htw_pkg::ST_DET_WR:   ctl.op = htw_pkg::OP_DET_WR;
      htw_pkg::ST_FIL_RD:   ctl.op = htw_pkg::OP_FIL_RD;
      htw_pkg::ST_FIL_WR:   ctl.op = htw_pkg::OP_FIL_WR;
      htw_pkg::ST_FIL_LINK: ctl.op = htw_pkg::OP_FIL_LINK;
      htw_pkg::ST_GET_RD:   ctl.op = htw_pkg::OP_GET_RD;
      htw_pkg::ST_GET_WR:   ctl.op = htw_pkg::OP_GET_WR;
      htw_pkg::ST_STP_INIT: ctl.op = htw_pkg::OP_STP_INIT;
      htw_pkg::ST_STP_SHF:  ctl.op = htw_pkg::OP_STP_SHF;
      htw_pkg::ST_STP_DUE:  ctl.op = htw_pkg::OP_STP_DUE;
      htw_pkg::ST_STP_SCAN: ctl.op = htw_pkg::OP_STP_SCAN;
      htw_pkg::ST_STP_SPL:  ctl.op = htw_pkg::OP_STP_SPL;
      htw_pkg::ST_STP_NEXT: ctl.op = htw_pkg::OP_STP_NEXT;
      htw_pkg::ST_STP_CUR:  ctl.op = htw_pkg::OP_STP_CUR;
      htw_pkg::ST_REF_RD:   ctl.op = htw_pkg::OP_REF_RD;
      htw_pkg::ST_REF_WR:   ctl.op = htw_pkg::OP_REF_WR;
      htw_pkg::ST_NW_INIT:  ctl.op = htw_pkg::OP_NW_INIT;
      htw_pkg::ST_NW_ROT:   ctl.op = htw_pkg::OP_NW_ROT;
      htw_pkg::ST_NW_CTZ:   ctl.op = htw_pkg::OP_NW_CTZ;
      htw_pkg::ST_NW_CMP:   ctl.op = htw_pkg::OP_NW_CMP;
      htw_pkg::ST_DONE:     ctl.op = stat.out_free ? htw_pkg::OP_DONE : htw_pkg::OP_NONE;
      default:              ctl.op = htw_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/htw_dp.sv =====
module htw_dp #(
  parameter int SLOT_BITS   = htw_pkg::SLOT_BITS,
  parameter int LEVEL_COUNT = htw_pkg::LEVEL_COUNT,
  parameter int TIMER_COUNT = htw_pkg::TIMER_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  htw_pkg::request_t  request,
  input  logic               result_stall,
  output logic               result_valid,
  output htw_pkg::result_t   result,
  input  htw_pkg::ctrl_cmd_t ctl,
  output htw_pkg::dp_stat_t  stat
);

  localparam int WL  = 1 << SLOT_BITS;
  localparam int ST  = LEVEL_COUNT * WL;
  localparam int SW  = $clog2(ST);
  localparam int LVW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int TW  = $clog2(TIMER_COUNT);
  localparam int PW  = $clog2(TIMER_COUNT + 1);
  localparam logic [PW-1:0]   NIL  = PW'(TIMER_COUNT);
  localparam logic [LVW-1:0]  LAST = LVW'(LEVEL_COUNT - 1);
  localparam logic [WL-1:0]   SMASK = WL'(WL - 1);

  function automatic logic [WL-1:0] rot_l(input logic [WL-1:0] v,
                                          input logic [SLOT_BITS-1:0] c);
    logic [2*WL-1:0] d;
    d = {v, v} << c;
    return d[2*WL-1:WL];
  endfunction

  function automatic logic [WL-1:0] rot_r(input logic [WL-1:0] v,
                                          input logic [SLOT_BITS-1:0] c);
    logic [2*WL-1:0] d;
    d = {v, v} >> c;
    return d[WL-1:0];
  endfunction

  function automatic logic [SLOT_BITS-1:0] ctz(input logic [WL-1:0] v);
    logic [SLOT_BITS-1:0] r;
    r = '0;
    for (int i = WL - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_BITS'(i);
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] slot_idx(input logic [LVW-1:0] l,
                                             input logic [SLOT_BITS-1:0] s);
    return (SW'(l) << SLOT_BITS) | SW'(s);
  endfunction

  function automatic logic [LVW-1:0] slot_lvl(input logic [SW-1:0] x);
    return LVW'(x >> SLOT_BITS);
  endfunction

  function automatic logic [6:0] lvl_sh(input logic [LVW-1:0] l);
    return 7'(int'(l) * SLOT_BITS);
  endfunction

  // control and working registers
  logic [WL-1:0]        bm [LEVEL_COUNT];
  logic [TIMER_COUNT-1:0] q;
  logic [PW-1:0]        exp_head, todo_head, todo_tail, link_h;
  logic [63:0]          cur, fexp, elapsed, el_sh, best;
  logic [1:0]           req_cmd;
  logic                 id_ok;
  logic [63:0]          req_tv;
  logic [TW-1:0]        cur_t;
  logic                 tgt_exp;
  logic [SW-1:0]        tgt_slot;
  logic [LVW-1:0]       lvl;
  logic [SLOT_BITS-1:0] now_s, spl_s, cz;
  logic [WL-1:0]        due, rot;
  logic                 occ;
  logic                 pop_v;
  logic [TW-1:0]        pop_id;

  // memories
  logic [PW-1:0]   nxt_mem [TIMER_COUNT];
  logic [PW-1:0]   prv_mem [TIMER_COUNT];
  logic [63:0]     exp_mem [TIMER_COUNT];
  logic [SW:0]     loc_mem [TIMER_COUNT];
  logic [PW-1:0]   hd_mem  [ST];
  logic [PW-1:0]   tl_mem  [ST];
  logic [PW-1:0]   nxt_rd, prv_rd, hd_rd, tl_rd;
  logic [63:0]     exp_rd;
  logic [SW:0]     loc_rd;

  logic            nxt_we, prv_we, exp_we, loc_we, hd_we, tl_we;
  logic [TW-1:0]   nxt_wa, prv_wa, nxt_ra, exp_ra;
  logic [PW-1:0]   nxt_wd, prv_wd, hd_wd, tl_wd;
  logic [SW-1:0]   hd_wa, tl_wa, hd_ra, tl_ra;
  logic [SW:0]     loc_wd;

  logic [15:0]     id_w;
  assign id_w = 16'(request.timer_id);

  // filing target for the timer in hand
  logic [63:0]          rem, fsh;
  logic [LVW-1:0]       tw;
  logic [SLOT_BITS-1:0] ts;
  logic                 tgt_exp_c;
  logic [SW-1:0]        tgt_slot_c;
  always_comb begin
    tgt_exp_c = !(fexp > cur);
    rem = fexp - cur;
    tw = '0;
    for (int k = 1; k < LEVEL_COUNT; k++) begin
      if ((rem >> (k * SLOT_BITS)) != 64'd0) tw = LVW'(k);
    end
    fsh = fexp >> lvl_sh(tw);
    ts = fsh[SLOT_BITS-1:0] - SLOT_BITS'(tw != '0);
    tgt_slot_c = slot_idx(tw, ts);
  end

  // detach operands
  logic [PW-1:0] dp_p, dp_n;
  logic          d_lexp;
  logic [SW-1:0] d_slot;
  assign dp_p   = prv_rd;
  assign dp_n   = nxt_rd;
  assign d_lexp = loc_rd[SW];
  assign d_slot = loc_rd[SW-1:0];

  logic [PW-1:0] fh;
  logic [WL-1:0] hit;
  logic [WL-1:0] bm_l;
  assign bm_l = bm[slot_lvl(tgt_slot)];
  assign fh  = tgt_exp ? exp_head :
               (bm_l[tgt_slot[SLOT_BITS-1:0]] ? hd_rd : NIL);
  assign hit = due & bm[lvl];

  logic [6:0]  sh;
  logic [63:0] span, relmask, nw_v;
  logic [WL:0] dmask;
  logic [SLOT_BITS-1:0] e;
  assign sh      = lvl_sh(lvl);
  assign span    = 64'(WL) << sh;
  assign relmask = (64'd1 << sh) - 64'd1;
  assign nw_v    = ((64'(cz) + 64'(lvl != '0)) << sh) - (cur & relmask);
  assign e       = el_sh[SLOT_BITS-1:0];
  assign dmask   = ((WL+1)'(1) << ({1'b0, e} + 1'b1)) - (WL+1)'(1);

  logic any;
  always_comb begin
    any = 1'b0;
    for (int i = 0; i < LEVEL_COUNT; i++) any = any | (bm[i] != '0);
  end

  // memory port selection
  always_comb begin
    nxt_we = 1'b0; nxt_wa = cur_t; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = cur_t; prv_wd = NIL;
    exp_we = 1'b0; loc_we = 1'b0;  loc_wd = {tgt_exp, tgt_slot};
    hd_we  = 1'b0; hd_wa  = tgt_slot; hd_wd = PW'(cur_t);
    tl_we  = 1'b0; tl_wa  = tgt_slot; tl_wd = PW'(cur_t);
    nxt_ra = cur_t;
    exp_ra = todo_head[TW-1:0];
    hd_ra  = slot_idx(lvl, ctz(hit));
    tl_ra  = slot_idx(lvl, ctz(hit));
    case (ctl.op)
      htw_pkg::OP_DET_WR: begin
        nxt_we = (dp_p != NIL);             nxt_wa = dp_p[TW-1:0]; nxt_wd = dp_n;
        prv_we = (dp_n != NIL);             prv_wa = dp_n[TW-1:0]; prv_wd = dp_p;
        hd_we  = (dp_p == NIL) && !d_lexp;  hd_wa  = d_slot;       hd_wd  = dp_n;
        tl_we  = (dp_n == NIL) && !d_lexp;  tl_wa  = d_slot;       tl_wd  = dp_p;
      end
      htw_pkg::OP_FIL_RD: begin
        exp_we = 1'b1;
        hd_ra  = tgt_slot_c;
      end
      htw_pkg::OP_FIL_WR: begin
        nxt_we = 1'b1; nxt_wd = fh;
        prv_we = 1'b1;
        loc_we = 1'b1;
        hd_we  = !tgt_exp;
        tl_we  = !tgt_exp && (fh == NIL);
      end
      htw_pkg::OP_FIL_LINK: begin
        prv_we = 1'b1; prv_wa = link_h[TW-1:0]; prv_wd = PW'(cur_t);
      end
      htw_pkg::OP_GET_RD: nxt_ra = exp_head[TW-1:0];
      htw_pkg::OP_GET_WR: begin
        prv_we = (nxt_rd != NIL); prv_wa = nxt_rd[TW-1:0];
      end
      htw_pkg::OP_STP_SPL: begin
        nxt_we = (todo_head != NIL); nxt_wa = todo_tail[TW-1:0]; nxt_wd = hd_rd;
      end
      htw_pkg::OP_REF_RD: nxt_ra = todo_head[TW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_ra];
  end
  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd <= prv_mem[cur_t];
  end
  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[cur_t] <= fexp;
    exp_rd <= exp_mem[exp_ra];
  end
  always_ff @(posedge clk) begin
    if (loc_we) loc_mem[cur_t] <= loc_wd;
    loc_rd <= loc_mem[cur_t];
  end
  always_ff @(posedge clk) begin
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    hd_rd <= hd_mem[hd_ra];
  end
  always_ff @(posedge clk) begin
    if (tl_we) tl_mem[tl_wa] <= tl_wd;
    tl_rd <= tl_mem[tl_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVEL_COUNT; i++) bm[i] <= '0;
      q            <= '0;
      exp_head     <= NIL;
      todo_head    <= NIL;
      cur          <= 64'd0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (ctl.op)
        htw_pkg::OP_DET_WR: begin
          if (dp_p == NIL && d_lexp) exp_head <= dp_n;
          if (dp_p == NIL && dp_n == NIL && !d_lexp)
            bm[slot_lvl(d_slot)][d_slot[SLOT_BITS-1:0]] <= 1'b0;
          q[cur_t] <= 1'b0;
        end
        htw_pkg::OP_FIL_WR: begin
          if (tgt_exp) exp_head <= PW'(cur_t);
          else bm[slot_lvl(tgt_slot)][tgt_slot[SLOT_BITS-1:0]] <= 1'b1;
          q[cur_t] <= 1'b1;
        end
        htw_pkg::OP_GET_WR: begin
          exp_head <= nxt_rd;
          q[exp_head[TW-1:0]] <= 1'b0;
        end
        htw_pkg::OP_STP_SPL: begin
          if (todo_head == NIL) todo_head <= hd_rd;
          bm[lvl][spl_s] <= 1'b0;
        end
        htw_pkg::OP_STP_CUR: cur <= req_tv;
        htw_pkg::OP_REF_WR:  todo_head <= nxt_rd;
        htw_pkg::OP_DONE:    result_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      htw_pkg::OP_LOAD: begin
        req_cmd <= request.cmd;
        req_tv  <= request.time_value;
        id_ok   <= (32'(request.timer_id) < TIMER_COUNT);
        cur_t   <= id_w[TW-1:0];
        fexp    <= request.time_value;
        pop_v   <= 1'b0;
        pop_id  <= '0;
      end
      htw_pkg::OP_FIL_RD: begin
        tgt_exp  <= tgt_exp_c;
        tgt_slot <= tgt_slot_c;
      end
      htw_pkg::OP_FIL_WR: link_h <= fh;
      htw_pkg::OP_GET_WR: begin
        pop_v  <= 1'b1;
        pop_id <= exp_head[TW-1:0];
      end
      htw_pkg::OP_STP_INIT: begin
        elapsed <= req_tv - cur;
        lvl     <= '0;
      end
      htw_pkg::OP_STP_SHF: begin
        el_sh <= elapsed >> sh;
        now_s <= SLOT_BITS'(req_tv >> sh);
      end
      htw_pkg::OP_STP_DUE: begin
        if (el_sh > 64'(SMASK)) due <= '1;
        else due <= rot_l(dmask[WL-1:0], now_s - e);
      end
      htw_pkg::OP_STP_SCAN: spl_s <= ctz(hit);
      htw_pkg::OP_STP_SPL:  todo_tail <= tl_rd;
      htw_pkg::OP_STP_NEXT: begin
        if (elapsed < span) elapsed <= span;
        lvl <= lvl + 1'b1;
      end
      htw_pkg::OP_REF_RD: cur_t <= todo_head[TW-1:0];
      htw_pkg::OP_REF_WR: fexp  <= exp_rd;
      htw_pkg::OP_NW_INIT: begin
        best <= '1;
        lvl  <= '0;
      end
      htw_pkg::OP_NW_ROT: begin
        rot <= rot_r(bm[lvl], SLOT_BITS'(cur >> sh));
        occ <= (bm[lvl] != '0);
      end
      htw_pkg::OP_NW_CTZ: cz <= ctz(rot);
      htw_pkg::OP_NW_CMP: begin
        if (occ && nw_v < best) best <= nw_v;
        if (lvl != LAST) lvl <= lvl + 1'b1;
      end
      htw_pkg::OP_DONE: begin
        result.expired_valid <= pop_v;
        result.expired_timer <= 6'(pop_id);
        result.any_pending   <= any;
        result.next_timeout  <= (exp_head != NIL) ? 64'd0 : best;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.cmd        = req_cmd;
    stat.id_ok      = id_ok;
    stat.queued     = q[cur_t];
    stat.exp_empty  = (exp_head == NIL);
    stat.h_nil      = (fh == NIL);
    stat.hit_any    = (hit != '0);
    stat.due0       = due[0];
    stat.lvl_last   = (lvl == LAST);
    stat.todo_empty = (todo_head == NIL);
    stat.out_free   = !result_valid || !result_stall;
  end

endmodule

// ===== rtl/core/hierarchical_timing_wheel_top.sv =====
// add, delete and get end with a next-expiry scan over every level when the expired list is empty
// step sweeps the levels, splices due slots onto a work list, refiles each timer on it, then ends the same way
// one request at a time: request_stall is high whenever the sequencer is not idle
// a new request is taken while the previous result still waits in the output register
// reset: synchronous, clears slot bitmaps, queued flags, expired and work lists, current time and result_valid
// slot head/tail memories need no clearing pass, the bitmap marks which entries are live
module hierarchical_timing_wheel_top #(
  parameter int SLOT_BITS   = htw_pkg::SLOT_BITS,
  parameter int LEVEL_COUNT = htw_pkg::LEVEL_COUNT,
  parameter int TIMER_COUNT = htw_pkg::TIMER_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  htw_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output htw_pkg::result_t  result
);

  // sequencer tells the datapath which micro-step to run each cycle
  htw_pkg::ctrl_cmd_t ctl;
  // datapath reports list and bitmap conditions back for branching
  htw_pkg::dp_stat_t  stat;

  htw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .ctl           (ctl),
    .stat          (stat)
  );

  // wheels, timer link memories, step sweep and next-expiry scan
  htw_dp #(
    .SLOT_BITS   (SLOT_BITS),
    .LEVEL_COUNT (LEVEL_COUNT),
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule

// ===== rtl/core/htw_checker.sv =====
`include "hierarchical_timing_wheel_top_defines.svh"

module htw_checker (
  input logic              clk,
  input logic              rst,
  input logic              request_valid,
  input logic              request_stall,
  input htw_pkg::request_t request,
  input logic              result_valid,
  input logic              result_stall,
  input htw_pkg::result_t  result
);

  `HTW_IMPLY(a_pop_id_zero, clk, rst, result_valid && !result.expired_valid, result.expired_timer == 6'd0, "timer id without a pop")
  `HTW_IMPLY(a_none_idle, clk, rst, result_valid && (result.next_timeout == '1), !result.any_pending, "no expiry while slots occupied")
  `HTW_NEXT(a_busy_after_req, clk, rst, request_valid && !request_stall, request_stall, "second request taken while busy")
  `HTW_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind hierarchical_timing_wheel_top htw_checker u_htw_checker (.*);

// ===== tb/hierarchical_timing_wheel_checker.sv =====
`timescale 1ns / 1ps

module hierarchical_timing_wheel_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  input  logic              request_stall,
  input  htw_pkg::request_t request,
  input  logic              result_valid,
  input  logic              result_stall,
  input  htw_pkg::result_t  result,
  output int                errors,
  output int                outstanding
);
  import htw_pkg::*;

  localparam int RING_SLOTS = 1 << SLOT_BITS;
  localparam int SLOT_TOTAL = LEVEL_COUNT * RING_SLOTS;
  localparam int EXP_LIST   = SLOT_TOTAL;
  localparam int WORK_LIST  = SLOT_TOTAL + 1;
  localparam int OFF_WHEEL  = SLOT_TOTAL + 2;
  localparam int NIL        = TIMER_COUNT;
  localparam logic [63:0] SPAN_MAX = (64'd1 << (SLOT_BITS * LEVEL_COUNT)) - 64'd1;
  localparam logic [63:0] SMASK = 64'(RING_SLOTS - 1);

  logic [63:0] occ[LEVEL_COUNT];
  int          lhead[SLOT_TOTAL + 2];
  int          ltail[SLOT_TOTAL + 2];
  int          tnext[TIMER_COUNT];
  int          tprev[TIMER_COUNT];
  logic [63:0] texp[TIMER_COUNT];
  int          tloc[TIMER_COUNT];
  logic [63:0] wheel_now;

  result_t expected_results[$];

  assign outstanding = expected_results.size();

  function automatic logic [63:0] rotl(logic [63:0] v, int c);
    c = c & (RING_SLOTS - 1);
    if (c == 0) return v;
    return (v << c) | (v >> (RING_SLOTS - c));
  endfunction

  function automatic logic [63:0] rotr(logic [63:0] v, int c);
    c = c & (RING_SLOTS - 1);
    if (c == 0) return v;
    return (v >> c) | (v << (RING_SLOTS - c));
  endfunction

  function automatic int ctz(logic [63:0] v);
    int n;
    n = 0;
    while (n < 64 && !v[n]) n++;
    return n;
  endfunction

  function automatic int msb_pos(logic [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic void wheel_clear();
    for (int i = 0; i < LEVEL_COUNT; i++) occ[i] = '0;
    for (int i = 0; i < SLOT_TOTAL + 2; i++) begin
      lhead[i] = NIL;
      ltail[i] = NIL;
    end
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tnext[i] = 0;
      tprev[i] = 0;
      texp[i]  = '0;
      tloc[i]  = OFF_WHEEL;
    end
    wheel_now = '0;
  endfunction

  function automatic void unlink(int l, int t);
    int p, n;
    p = tprev[t];
    n = tnext[t];
    if (p >= NIL) lhead[l] = n; else tnext[p] = n;
    if (n >= NIL) ltail[l] = p; else tprev[n] = p;
  endfunction

  function automatic void push_front(int l, int t);
    int h;
    h = lhead[l];
    tprev[t] = NIL;
    tnext[t] = h;
    if (h >= NIL) ltail[l] = t; else tprev[h] = t;
    lhead[l] = t;
    tloc[t] = l;
  endfunction

  function automatic void push_back(int l, int t);
    int tl;
    tl = ltail[l];
    tnext[t] = NIL;
    tprev[t] = tl;
    if (tl >= NIL) lhead[l] = t; else tnext[tl] = t;
    ltail[l] = t;
    tloc[t] = l;
  endfunction

  function automatic void take_off(int t);
    int l;
    l = tloc[t];
    if (l >= OFF_WHEEL) return;
    unlink(l, t);
    if (l < SLOT_TOTAL && lhead[l] >= NIL)
      occ[l / RING_SLOTS][l % RING_SLOTS] = 1'b0;
    tloc[t] = OFF_WHEEL;
  endfunction

  function automatic void place_timer(int t, logic [63:0] exp_at);
    logic [63:0] rem;
    int w, s;
    take_off(t);
    texp[t] = exp_at;
    if (exp_at > wheel_now) begin
      rem = exp_at - wheel_now;
      if (rem > SPAN_MAX) rem = SPAN_MAX;
      w = (msb_pos(rem) - 1) / SLOT_BITS;
      if (w >= LEVEL_COUNT) w = LEVEL_COUNT - 1;
      s = int'(SMASK & ((exp_at >> (w * SLOT_BITS)) - ((w != 0) ? 64'd1 : 64'd0)));
      push_front(w * RING_SLOTS + s, t);
      occ[w][s] = 1'b1;
    end else begin
      push_front(EXP_LIST, t);
    end
  endfunction

  function automatic void advance_to(logic [63:0] now_v);
    logic [63:0] elapsed, due, hit, span;
    int sh, e, s, l, t, n;
    elapsed = now_v - wheel_now;
    for (int w = 0; w < LEVEL_COUNT; w++) begin
      sh = w * SLOT_BITS;
      if ((elapsed >> sh) > SMASK) begin
        due = '1;
      end else begin
        e = int'(SMASK & (elapsed >> sh));
        s = int'(SMASK & (now_v >> sh));
        due = rotr(rotl((64'd1 << e) - 64'd1, s), e);
        due[s] = 1'b1;
      end
      hit = due & occ[w];
      while (hit != 0) begin
        s = ctz(hit);
        l = w * RING_SLOTS + s;
        t = lhead[l];
        while (t < NIL) begin
          n = tnext[t];
          push_back(WORK_LIST, t);
          t = n;
        end
        lhead[l] = NIL;
        ltail[l] = NIL;
        occ[w][s] = 1'b0;
        hit = due & occ[w];
      end
      if (!due[0]) break;
      span = 64'(RING_SLOTS) << sh;
      if (elapsed < span) elapsed = span;
    end
    wheel_now = now_v;
    while (lhead[WORK_LIST] < NIL) begin
      t = lhead[WORK_LIST];
      unlink(WORK_LIST, t);
      tloc[t] = OFF_WHEEL;
      place_timer(t, texp[t]);
    end
  endfunction

  function automatic logic [63:0] time_to_next();
    logic [63:0] best, relmask, v;
    int sh, s;
    best = '1;
    relmask = '0;
    if (lhead[EXP_LIST] < NIL) return '0;
    for (int w = 0; w < LEVEL_COUNT; w++) begin
      if (occ[w] != 0) begin
        sh = w * SLOT_BITS;
        s = int'(SMASK & (wheel_now >> sh));
        v = 64'(ctz(rotr(occ[w], s)) + ((w != 0) ? 1 : 0)) << sh;
        v = v - (relmask & wheel_now);
        if (v < best) best = v;
      end
      relmask = (relmask << SLOT_BITS) | SMASK;
    end
    return best;
  endfunction

  function automatic result_t apply_request(request_t rq);
    result_t r;
    int t;
    r = '0;
    case (rq.cmd)
      CMD_ADD: if (rq.timer_id < TIMER_COUNT) place_timer(int'(rq.timer_id), rq.time_value);
      CMD_DEL: if (rq.timer_id < TIMER_COUNT) take_off(int'(rq.timer_id));
      CMD_STEP: advance_to(rq.time_value);
      default: begin
        t = lhead[EXP_LIST];
        if (t < NIL) begin
          unlink(EXP_LIST, t);
          tloc[t] = OFF_WHEEL;
          r.expired_valid = 1'b1;
          r.expired_timer = 6'(t);
        end
      end
    endcase
    for (int w = 0; w < LEVEL_COUNT; w++)
      if (occ[w] != 0) r.any_pending = 1'b1;
    r.next_timeout = time_to_next();
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      wheel_clear();
      expected_results.delete();
      errors <= 0;
    end else begin
      if (request_valid && !request_stall)
        expected_results.push_back(apply_request(request));
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %p", $time, result);
          bad++;
        end else begin
          want = expected_results.pop_front();
          if (want.expired_valid !== result.expired_valid) begin
            $display("%0t expired_valid: expected %0d actual %0d", $time,
                     want.expired_valid, result.expired_valid);
            bad++;
          end
          if (want.expired_timer !== result.expired_timer) begin
            $display("%0t expired_timer: expected %0d actual %0d", $time,
                     want.expired_timer, result.expired_timer);
            bad++;
          end
          if (want.any_pending !== result.any_pending) begin
            $display("%0t any_pending: expected %0d actual %0d", $time,
                     want.any_pending, result.any_pending);
            bad++;
          end
          if (want.next_timeout !== result.next_timeout) begin
            $display("%0t next_timeout: expected %h actual %h", $time,
                     want.next_timeout, result.next_timeout);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

endmodule

// ===== tb/hierarchical_timing_wheel_top_tb.sv =====
`timescale 1ns / 1ps

module hierarchical_timing_wheel_top_tb;
  import htw_pkg::*;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int QUIET_TAIL      = 250;   // last requests run with no idling
  localparam int WATCHDOG_LIMIT  = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;

  int errors;
  int outstanding;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  // software view of the wheel clock, used to aim expiries near it
  logic [63:0] tb_now = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hierarchical_timing_wheel_top u_top (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  hierarchical_timing_wheel_checker u_checker (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .errors(errors), .outstanding(outstanding)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) results_seen++;
      if ((request_valid && !request_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("TB_ERROR");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // one request: optional idle burst, then hold until accepted
  task automatic send(logic [1:0] cmd, logic [5:0] id, logic [63:0] tv);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid <= 1'b1;
    request <= '{cmd: cmd, timer_id: id, time_value: tv};
    @(posedge clk);
    while (request_stall) @(posedge clk);
    sent++;
    if (cmd == CMD_STEP) tb_now = tv;
  endtask

  // distance mix covering every wheel level, already-due and saturated expiries
  function automatic logic [63:0] pick_expiry();
    case ($urandom_range(0, 9))
      0: return tb_now - 64'($urandom_range(0, 100));
      1, 2: return tb_now + 64'($urandom_range(1, 63));
      3, 4: return tb_now + 64'($urandom_range(64, 4095));
      5: return tb_now + 64'($urandom_range(4096, 262143));
      6: return tb_now + 64'($urandom_range(262144, 16777215));
      7: return tb_now + {$urandom(), $urandom()};
      default: return tb_now + 64'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [63:0] pick_step();
    case ($urandom_range(0, 19))
      0: return tb_now - 64'($urandom_range(1, 500));      // backwards, wraps
      1: return {$urandom(), $urandom()};
      2, 3: return tb_now + 64'($urandom_range(4096, 1048575));
      4, 5, 6: return tb_now + 64'($urandom_range(64, 4095));
      default: return tb_now + 64'($urandom_range(0, 70));
    endcase
  endfunction

  initial begin
    logic [1:0] c;
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every command, each corner case
    send(CMD_GET, 6'd0, 64'd0);                      // get on empty expired list
    send(CMD_ADD, 6'd0, 64'd0);                      // expiry not after now
    send(CMD_ADD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);   // beyond span, saturates
    send(CMD_ADD, 6'd1, 64'd1);
    send(CMD_ADD, 6'd2, 64'd64);
    send(CMD_ADD, 6'd3, 64'd4096);
    send(CMD_ADD, 6'd4, 64'd262144);
    send(CMD_ADD, 6'd5, 64'd16777215);
    send(CMD_DEL, 6'd10, 64'd0);                     // delete of a timer not queued
    send(CMD_ADD, 6'd2, 64'd65);                     // re-add while queued
    send(CMD_DEL, 6'd3, 64'hFFFF_FFFF_FFFF_FFFF);    // delete empties a slot
    send(CMD_GET, 6'd63, 64'd0);
    send(CMD_GET, 6'd0, 64'd0);
    send(CMD_STEP, 6'd0, 64'd1);
    send(CMD_STEP, 6'd0, 64'd70);
    send(CMD_GET, 6'd0, 64'd0);
    send(CMD_GET, 6'd0, 64'd0);
    send(CMD_STEP, 6'd0, 64'd20);                    // step backwards
    send(CMD_STEP, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_ADD, 6'd7, 64'h0);
    send(CMD_STEP, 6'd0, 64'h0);
    repeat (6) send(CMD_GET, 6'd0, 64'd0);

    // random: mostly add/step/get sequences around the wheel clock
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) begin
        // sender holds off until the block has drained
        request_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if (i == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) c = CMD_ADD;
      else if (pick < 45) c = CMD_DEL;
      else if (pick < 70) c = CMD_STEP;
      else c = CMD_GET;
      case (c)
        CMD_ADD: send(c, 6'($urandom()), pick_expiry());
        CMD_STEP: send(c, 6'($urandom()), pick_step());
        default: send(c, 6'($urandom()), {$urandom(), $urandom()});
      endcase
    end

    request_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d requests (add, delete, step, get), checked %0d results",
             sent, results_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/htw_pkg.sv
rtl/core/htw_ctrl.sv
rtl/core/htw_dp.sv
rtl/core/hierarchical_timing_wheel_top.sv
rtl/core/htw_checker.sv
tb/hierarchical_timing_wheel_checker.sv
tb/hierarchical_timing_wheel_top_tb.sv
